[rtl/core/ofpl_pkg.sv]
// ============================================================================
// ofpl_pkg
// Shared types and constants of the output fault protection lock.
// ============================================================================
package ofpl_pkg;

    // Default channel count and its legal range.
    localparam int CHANNELS_DEF = 8;
    localparam int CHANNELS_MAX = 32;

    // Widths of the fields on the ports.
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 8;
    localparam int CHAN_W   = 3;
    localparam int TIME_W   = 32;
    localparam int OUT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [TIME_W-1:0] LOCK_MS_DEF = TIME_W'(10000);

    typedef enum logic [CMD_W-1:0] {
        CMD_OV_REPORT = 2'd0,
        CMD_TH_REPORT = 2'd1,
        CMD_DRIVE_WR  = 2'd2,
        CMD_MODE_WR   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OV_ENABLE = 2'd0,
        REG_OV_TIME   = 2'd1,
        REG_TH_TIME   = 2'd2
    } t_reg_idx;

    // State bits of one channel.
    typedef struct packed {
        logic drive;
        logic pushpull;
        logic ov_lock;
        logic th_lock;
        logic user_drive;
        logic user_pushpull;
    } t_lane_bits;

endpackage

[rtl/core/ofpl_in_if.sv]
// ============================================================================
// ofpl_in_if
// Command channel: valid/ready handshake and one command word.
// ============================================================================
interface ofpl_in_if;
    import ofpl_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [STATUS_W-1:0] status_bits;
    logic [CHAN_W-1:0]   channel;
    logic                level;
    logic [TIME_W-1:0]   now_ms;

    modport source (
        output valid, command, status_bits, channel, level, now_ms,
        input  ready
    );

    modport sink (
        input  valid, command, status_bits, channel, level, now_ms,
        output ready
    );
endinterface

[rtl/core/ofpl_out_if.sv]
// ============================================================================
// ofpl_out_if
// Result channel: valid/ready handshake and one result word.
// ============================================================================
interface ofpl_out_if;
    import ofpl_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] drive_bits;
    logic [OUT_W-1:0] pushpull_bits;
    logic [OUT_W-1:0] ov_lock_bits;
    logic [OUT_W-1:0] thermal_lock_bits;
    logic             accepted;

    modport source (
        output valid, drive_bits, pushpull_bits, ov_lock_bits, thermal_lock_bits,
               accepted,
        input  ready
    );

    modport sink (
        input  valid, drive_bits, pushpull_bits, ov_lock_bits, thermal_lock_bits,
               accepted,
        output ready
    );
endinterface

[rtl/core/output_fault_protection_lock.sv]
// ============================================================================
// output_fault_protection_lock
// Overvoltage and thermal lock handling for a bank of output channels.
// ============================================================================
//   channel   dir  handshake       word
//   i_cmd     in   valid / ready   command, status_bits, channel, level, now_ms
//   o_res     out  valid / ready   drive/pushpull/lock bits, accepted
//   i_cfg_*   in   write enable    register index, 32-bit data
//
// One word per cycle sustained while the result channel is ready. A word waits
// in the input register, where all channel lanes (one 32-bit elapsed-time compare
// each) update the state, then the result register holds the answer.
// A stalled result register holds its word; the input register still takes
// one more word. Reset (synchronous, active low) clears state (but not the time stamps) and config.
// ============================================================================
module output_fault_protection_lock
    import ofpl_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ofpl_in_if.sink               i_cmd,
    ofpl_out_if.source            o_res
);

    localparam int EXT_W = (CHANNELS > OUT_W) ? CHANNELS : OUT_W;

    // configuration
    logic              r_ov_en;
    logic [TIME_W-1:0] r_ov_time;
    logic [TIME_W-1:0] r_th_time;

    // input register
    logic                r_in_valid;
    t_cmd                r_cmd;
    logic [STATUS_W-1:0] r_status;
    logic [CHAN_W-1:0]   r_chan;
    logic                r_level;
    logic [TIME_W-1:0]   r_now;

    // channel state
    logic [CHANNELS-1:0] r_drive, n_drive;
    logic [CHANNELS-1:0] r_pp, n_pp;
    logic [CHANNELS-1:0] r_user_drive, n_user_drive;
    logic [CHANNELS-1:0] r_user_pp, n_user_pp;
    logic [CHANNELS-1:0] r_ov_lock, n_ov_lock;
    logic [CHANNELS-1:0] r_th_lock, n_th_lock;
    logic [TIME_W-1:0]   r_stamp [CHANNELS];

    // result register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_drive;
    logic [OUT_W-1:0] r_out_pp;
    logic [OUT_W-1:0] r_out_ov;
    logic [OUT_W-1:0] r_out_th;
    logic             r_out_acc;

    logic                accept;
    logic                advance;
    logic [EXT_W-1:0]    flags_ext;
    logic [CHANNELS-1:0] flags;
    logic [CHANNELS-1:0] stamp_we;
    logic [CHANNELS-1:0] lane_refused;
    logic                chan_oob;
    logic                refused;
    logic [EXT_W-1:0]    ext_drive, ext_pp, ext_ov, ext_th;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || advance;
    assign accept      = i_cmd.valid && i_cmd.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov_en   <= 1'b0;
            r_ov_time <= LOCK_MS_DEF;
            r_th_time <= LOCK_MS_DEF;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_OV_ENABLE: r_ov_en   <= i_cfg_data[0];
                REG_OV_TIME:   r_ov_time <= i_cfg_data[TIME_W-1:0];
                REG_TH_TIME:   r_th_time <= i_cfg_data[TIME_W-1:0];
                default:       r_ov_en   <= r_ov_en;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= t_cmd'(i_cmd.command);
            r_status <= i_cmd.status_bits;
            r_chan   <= i_cmd.channel;
            r_level  <= i_cmd.level;
            r_now    <= i_cmd.now_ms;
        end
    end

    // status flags exist only for the low channels
    assign flags_ext = EXT_W'(r_status);
    assign flags     = flags_ext[CHANNELS-1:0];

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        t_lane_bits cur;
        t_lane_bits nxt;
        logic       sel;

        assign sel = (32'(r_chan) == 32'(g));
        assign cur = '{drive:         r_drive[g],
                       pushpull:      r_pp[g],
                       ov_lock:       r_ov_lock[g],
                       th_lock:       r_th_lock[g],
                       user_drive:    r_user_drive[g],
                       user_pushpull: r_user_pp[g]};

        ofpl_lane u_lane (
            .i_cmd      (r_cmd),
            .i_ov_en    (r_ov_en),
            .i_flag     (flags[g]),
            .i_sel      (sel),
            .i_level    (r_level),
            .i_now      (r_now),
            .i_stamp    (r_stamp[g]),
            .i_ov_time  (r_ov_time),
            .i_th_time  (r_th_time),
            .i_cur      (cur),
            .o_nxt      (nxt),
            .o_stamp_we (stamp_we[g]),
            .o_refused  (lane_refused[g])
        );

        assign n_drive[g]      = nxt.drive;
        assign n_pp[g]         = nxt.pushpull;
        assign n_ov_lock[g]    = nxt.ov_lock;
        assign n_th_lock[g]    = nxt.th_lock;
        assign n_user_drive[g] = nxt.user_drive;
        assign n_user_pp[g]    = nxt.user_pushpull;

        always_ff @(posedge i_clk) begin
            if (advance && stamp_we[g]) begin
                r_stamp[g] <= r_now;
            end
        end
    end

    // a write to a channel that does not exist is refused
    assign chan_oob = (32'(r_chan) >= 32'(CHANNELS)) &&
                      (r_cmd == CMD_DRIVE_WR || r_cmd == CMD_MODE_WR);
    assign refused  = chan_oob || (|lane_refused);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive      <= '0;
            r_pp         <= '0;
            r_user_drive <= '0;
            r_user_pp    <= '0;
            r_ov_lock    <= '0;
            r_th_lock    <= '0;
        end else if (advance) begin
            r_drive      <= n_drive;
            r_pp         <= n_pp;
            r_user_drive <= n_user_drive;
            r_user_pp    <= n_user_pp;
            r_ov_lock    <= n_ov_lock;
            r_th_lock    <= n_th_lock;
        end
    end

    // report only the low channels
    assign ext_drive = EXT_W'(n_drive);
    assign ext_pp    = EXT_W'(n_pp);
    assign ext_ov    = EXT_W'(n_ov_lock);
    assign ext_th    = EXT_W'(n_th_lock);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_drive <= ext_drive[OUT_W-1:0];
            r_out_pp    <= ext_pp[OUT_W-1:0];
            r_out_ov    <= ext_ov[OUT_W-1:0];
            r_out_th    <= ext_th[OUT_W-1:0];
            r_out_acc   <= !refused;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.drive_bits        = r_out_drive;
    assign o_res.pushpull_bits     = r_out_pp;
    assign o_res.ov_lock_bits      = r_out_ov;
    assign o_res.thermal_lock_bits = r_out_th;
    assign o_res.accepted          = r_out_acc;

    // a thermally locked channel never runs push-pull
    a_th_lock_no_pp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_th_lock & r_pp) == '0)
        else $error("thermal lock with push-pull active");

    // overvoltage locks are only taken by an overvoltage report
    a_ov_lock_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|(n_ov_lock & ~r_ov_lock)) && advance |-> r_cmd == CMD_OV_REPORT)
        else $error("overvoltage lock set by a non-report word");

    // thermal locks are only taken by a thermal report
    a_th_lock_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|(n_th_lock & ~r_th_lock)) && advance |-> r_cmd == CMD_TH_REPORT)
        else $error("thermal lock set by a non-report word");

    // a word that leaves the input register shows up as a result next cycle
    a_advance_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced word lost");

    // reports are never refused
    a_report_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_cmd == CMD_OV_REPORT || r_cmd == CMD_TH_REPORT) |=> r_out_acc)
        else $error("report word refused");

endmodule

[rtl/core/ofpl_lane.sv]
// ============================================================================
// ofpl_lane
// Next-state logic of one output channel: fault reports, lock expiry and
// user writes.
// ============================================================================
module ofpl_lane
    import ofpl_pkg::*;
(
    input  t_cmd               i_cmd,
    input  logic               i_ov_en,
    input  logic               i_flag,
    input  logic               i_sel,
    input  logic               i_level,
    input  logic [TIME_W-1:0]  i_now,
    input  logic [TIME_W-1:0]  i_stamp,
    input  logic [TIME_W-1:0]  i_ov_time,
    input  logic [TIME_W-1:0]  i_th_time,
    input  t_lane_bits         i_cur,
    output t_lane_bits         o_nxt,
    output logic               o_stamp_we,
    output logic               o_refused
);

    logic [TIME_W-1:0] lock_time;
    logic [TIME_W-1:0] elapsed;
    logic              expired;
    logic              ov_set;
    logic              th_set;

    // One elapsed-time compare serves both report kinds.
    assign lock_time = (i_cmd == CMD_TH_REPORT) ? i_th_time : i_ov_time;
    assign elapsed   = i_now - i_stamp;
    assign expired   = elapsed > lock_time;

    assign ov_set = i_flag && !i_cur.pushpull && (!i_cur.drive || i_cur.ov_lock);
    assign th_set = i_flag && (i_cur.pushpull || i_cur.th_lock) &&
                    (!i_cur.drive || i_cur.th_lock);

    always_comb begin
        o_nxt      = i_cur;
        o_stamp_we = 1'b0;
        o_refused  = 1'b0;
        case (i_cmd)
            CMD_OV_REPORT: begin
                if (i_ov_en) begin
                    if (ov_set) begin
                        o_nxt.ov_lock = 1'b1;
                        o_nxt.drive   = 1'b1;
                        o_stamp_we    = 1'b1;
                    end else if (i_cur.ov_lock && expired) begin
                        o_nxt.drive   = i_cur.user_drive;
                        o_nxt.ov_lock = 1'b0;
                    end
                end
            end
            CMD_TH_REPORT: begin
                if (th_set) begin
                    o_nxt.th_lock  = 1'b1;
                    o_nxt.pushpull = 1'b0;
                    o_nxt.drive    = 1'b0;
                    o_stamp_we     = 1'b1;
                end else if (i_cur.th_lock && expired) begin
                    o_nxt.pushpull = i_cur.user_pushpull;
                    o_nxt.drive    = i_cur.user_drive;
                    o_nxt.th_lock  = 1'b0;
                end
            end
            CMD_DRIVE_WR: begin
                if (i_sel) begin
                    o_nxt.user_drive = i_level;
                    // remember the request, refuse to clear the drive while an overvoltage lock holds
                    if (i_cur.ov_lock && !i_level) begin
                        o_refused = 1'b1;
                    end else begin
                        o_nxt.drive = i_level;
                    end
                end
            end
            CMD_MODE_WR: begin
                if (i_sel) begin
                    o_nxt.user_pushpull = i_level;
                    if (i_cur.th_lock && i_level) begin
                        o_refused = 1'b1;
                    end else begin
                        o_nxt.pushpull = i_level;
                    end
                end
            end
            default: begin
                o_nxt = i_cur;
            end
        endcase
    end

endmodule
